>>> src/sskq_pkg.sv
package sskq_pkg;

  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int HANDLE_BITS  = 16;
  localparam int KEY_BITS     = 64;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_REKEY  = 3'd2,
    OP_READ   = 3'd3,
    OP_FIND   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HSCAN,
    S_KSCAN,
    S_READ
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [HANDLE_BITS-1:0]  handle;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   del;
    idx_t   pos;
    entry_t ent;
  } store_cmd_t;

  typedef struct packed {
    logic key_gt;
    logic key_eq;
    logic handle_eq;
  } cmp_t;

endpackage

>>> src/sskq_if.sv
interface sskq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] key;
  logic [31:0] payload;
  logic [15:0] handle;
  logic [3:0]  position;

  modport source (output valid, output op, output key, output payload, output handle,
                  output position, input ready);
  modport sink (input valid, input op, input key, input payload, input handle,
                input position, output ready);
endinterface

interface sskq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_key;
  logic [31:0] out_payload;
  logic [15:0] out_handle;
  logic [3:0]  out_position;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output out_key, output out_payload,
                  output out_handle, output out_position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input out_key, input out_payload,
                input out_handle, input out_position, input entry_count,
                output ready);
endinterface

>>> src/sskq_store.sv
module sskq_store import sskq_pkg::*; (
  input  logic                   clk_i,
  input  store_cmd_t             cmd_i,
  input  idx_t                   rd_idx_i,
  input  logic [KEY_BITS-1:0]    cmp_key_i,
  input  logic [HANDLE_BITS-1:0] cmp_handle_i,
  output entry_t                 rd_o,
  output cmp_t                   cmp_o
);

  entry_t ent_q [CAPACITY];

  assign rd_o             = ent_q[rd_idx_i];
  assign cmp_o.key_gt     = rd_o.key > cmp_key_i;
  assign cmp_o.key_eq     = rd_o.key == cmp_key_i;
  assign cmp_o.handle_eq  = rd_o.handle == cmp_handle_i;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;
    entry_t ent_d;
    logic   wr_en;

    always_comb begin
      ent_d = cmd_i.ent;
      wr_en = 1'b0;
      if (cmd_i.ins) begin
        if (idx_t'(g) == cmd_i.pos) begin
          wr_en = 1'b1;
        end else if (idx_t'(g) > cmd_i.pos) begin
          ent_d = ent_q[PREV];
          wr_en = 1'b1;
        end
      end else if (cmd_i.del) begin
        if ((idx_t'(g) >= cmd_i.pos) && (g < CAPACITY - 1)) begin
          ent_d = ent_q[NEXT];
          wr_en = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        ent_q[g] <= ent_d;
      end
    end
  end

endmodule

>>> src/stable_sorted_key_queue.sv
// Channel | Dir | Fields                                              | Accept
// req_i   | in  | op, key, payload, handle, position                  | valid & ready
// rsp_o   | out | status, out_key, out_payload, out_handle,           | valid & ready
//         |     | out_position, entry_count                           |
// One shared key/handle comparator walks the entries one position per cycle.
// Clear, full add, bad op and out-of-range read answer from idle; read goes via S_READ.
// Add and find scan by key to the slot or hit; delete scans by handle; rekey scans by
// handle, then by key. Insert and remove shift every cell at or above the position at once.
// Reset empties the queue and zeroes the handle counter; no clearing pass.
// A request is taken only when idle and the result register is free or draining.
module stable_sorted_key_queue import sskq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sskq_req_if.sink    req_i,
  sskq_rsp_if.source  rsp_o
);

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pl_q, pl_d;
  logic [HANDLE_BITS-1:0]  h_q, h_d;
  logic [HANDLE_BITS-1:0]  ctr_q, ctr_d;
  cnt_t                    scan_q, scan_d;
  cnt_t                    cnt_q, cnt_d;

  logic                    out_valid_q;
  status_e                 status_q;
  logic [63:0]             okey_q;
  logic [31:0]             opl_q;
  logic [15:0]             oh_q;
  logic [3:0]              opos_q;
  logic [4:0]              ocnt_q;

  store_cmd_t              cmd;
  entry_t                  rd;
  cmp_t                    cmp;

  logic                    out_free;
  logic                    in_ready;
  logic                    accept;
  logic                    scan_end;
  logic                    pos_fits;
  logic                    res_we;
  logic                    res_hit;
  status_e                 res_status;
  entry_t                  res_ent;

  sskq_store u_store (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .rd_idx_i    (scan_q[IDX_W-1:0]),
    .cmp_key_i   (key_q),
    .cmp_handle_i(h_q),
    .rd_o        (rd),
    .cmp_o       (cmp)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign in_ready    = (state_q == S_IDLE) && out_free;
  assign accept      = req_i.valid && in_ready;
  assign scan_end    = scan_q == cnt_q;
  assign pos_fits    = 32'(req_i.position) < 32'(cnt_q);
  assign req_i.ready = in_ready;

  // datapath control
  always_comb begin
    op_d       = op_q;
    key_d      = key_q;
    pl_d       = pl_q;
    h_d        = h_q;
    ctr_d      = ctr_q;
    scan_d     = scan_q;
    cnt_d      = cnt_q;
    cmd        = '0;
    cmd.pos    = scan_q[IDX_W-1:0];
    cmd.ent    = '{key: key_q, payload: pl_q, handle: h_q};
    res_we     = 1'b0;
    res_hit    = 1'b0;
    res_status = STAT_MISS;
    res_ent    = rd;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = op_e'(req_i.op);
          key_d  = req_i.key;
          pl_d   = PAYLOAD_BITS'(req_i.payload);
          h_d    = HANDLE_BITS'(req_i.handle);
          scan_d = '0;
          case (op_e'(req_i.op))
            OP_ADD: begin
              h_d = ctr_q;
              if (cnt_q == cnt_t'(CAPACITY)) begin
                res_we     = 1'b1;
                res_status = STAT_FULL;
              end
            end
            OP_DELETE, OP_REKEY, OP_FIND: begin
            end
            OP_READ: begin
              if (pos_fits) begin
                scan_d = cnt_t'(req_i.position);
              end else begin
                res_we = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_d      = '0;
              res_we     = 1'b1;
              res_status = STAT_OK;
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      S_HSCAN: begin
        if (scan_end) begin
          res_we = out_free;
        end else if (cmp.handle_eq) begin
          if (op_q == OP_DELETE) begin
            if (out_free) begin
              res_we     = 1'b1;
              res_hit    = 1'b1;
              res_status = STAT_OK;
              cmd.del    = 1'b1;
              cnt_d      = cnt_q - 1'b1;
            end
          end else begin
            pl_d    = rd.payload;
            h_d     = rd.handle;
            cmd.del = 1'b1;
            cnt_d   = cnt_q - 1'b1;
            scan_d  = '0;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_KSCAN: begin
        if (op_q == OP_FIND) begin
          if (scan_end) begin
            res_we = out_free;
          end else if (cmp.key_eq) begin
            res_we     = out_free;
            res_hit    = 1'b1;
            res_status = STAT_OK;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end else if (scan_end || cmp.key_gt) begin
          if (out_free) begin
            cmd.ins    = 1'b1;
            res_we     = 1'b1;
            res_hit    = 1'b1;
            res_status = STAT_OK;
            res_ent    = cmd.ent;
            cnt_d      = cnt_q + 1'b1;
            if (op_q == OP_ADD) begin
              ctr_d = ctr_q + 1'b1;
            end
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_READ: begin
        res_we     = out_free;
        res_hit    = 1'b1;
        res_status = STAT_OK;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !res_we) begin
          case (op_e'(req_i.op))
            OP_DELETE, OP_REKEY: state_d = S_HSCAN;
            OP_ADD, OP_FIND:     state_d = S_KSCAN;
            OP_READ:             state_d = S_READ;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_HSCAN: begin
        if (res_we) begin
          state_d = S_IDLE;
        end else if (!scan_end && cmp.handle_eq && (op_q == OP_REKEY)) begin
          state_d = S_KSCAN;
        end
      end
      S_KSCAN, S_READ: begin
        if (res_we) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ctr_q       <= '0;
      scan_q      <= '0;
      op_q        <= OP_ADD;
      out_valid_q <= 1'b0;
      status_q    <= STAT_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ctr_q   <= ctr_d;
      scan_q  <= scan_d;
      op_q    <= op_d;
      if (res_we) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pl_q  <= pl_d;
    h_q   <= h_d;
    if (res_we) begin
      ocnt_q <= 5'(cnt_d);
      if (res_hit) begin
        okey_q <= res_ent.key;
        opl_q  <= 32'(res_ent.payload);
        oh_q   <= 16'(res_ent.handle);
        opos_q <= 4'(scan_q);
      end else begin
        okey_q <= '0;
        opl_q  <= '0;
        oh_q   <= '0;
        opos_q <= '0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_key      = okey_q;
  assign rsp_o.out_payload  = opl_q;
  assign rsp_o.out_handle   = oh_q;
  assign rsp_o.out_position = opos_q;
  assign rsp_o.entry_count  = ocnt_q;

endmodule

>>> src/sskq_checker.sv
module sskq_checker import sskq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [2:0]  req_op_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [63:0] rsp_key_i,
  input logic [31:0] rsp_payload_i,
  input logic [15:0] rsp_handle_i,
  input logic [3:0]  rsp_position_i,
  input logic [4:0]  rsp_count_i
);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (CAPACITY > 31) || (32'(rsp_count_i) <= CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STAT_FULL) |-> 32'(rsp_count_i) == (CAPACITY % 32))
    else $error("full status with queue not full");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STAT_OK) |->
      (rsp_key_i == '0) && (rsp_payload_i == '0) && (rsp_handle_i == '0) &&
      (rsp_position_i == '0))
    else $error("error result carries entry fields");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_op_i == OP_CLEAR) |=>
      rsp_valid_i && (rsp_status_i == STAT_OK) && (rsp_count_i == '0))
    else $error("clear request without empty ok result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_key_i) &&
      $stable(rsp_status_i))
    else $error("stalled result changed");

endmodule

bind stable_sorted_key_queue sskq_checker u_sskq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_op_i      (req_i.op),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_key_i     (rsp_o.out_key),
  .rsp_payload_i (rsp_o.out_payload),
  .rsp_handle_i  (rsp_o.out_handle),
  .rsp_position_i(rsp_o.out_position),
  .rsp_count_i   (rsp_o.entry_count)
);
